>>> hw/rtl/x64e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x64e_pkg
// Types, form codes and opcode constants shared by the x86-64 encoder.
// ----------------------------------------------------------------------------
package x64e_pkg;

  localparam int MaxCode    = 10;
  localparam int IdxW       = $clog2(MaxCode);
  localparam int QueueDepth = 2;

  typedef enum logic [4:0] {
    FORM_PUSH_REG   = 5'd0,
    FORM_PUSH_IMM   = 5'd1,
    FORM_PUSH_MEM   = 5'd2,
    FORM_POP_REG    = 5'd3,
    FORM_POP_MEM    = 5'd4,
    FORM_SUB_IMM    = 5'd5,
    FORM_SUB_REG    = 5'd6,
    FORM_ADD_IMM    = 5'd7,
    FORM_ADD_REG    = 5'd8,
    FORM_IDIV       = 5'd9,
    FORM_IMUL       = 5'd10,
    FORM_MOV_REG    = 5'd11,
    FORM_MOV_MEM    = 5'd12,
    FORM_MOV_IMM64  = 5'd13,
    FORM_JMP        = 5'd14,
    FORM_JZ         = 5'd15,
    FORM_CALL       = 5'd16,
    FORM_XOR        = 5'd17,
    FORM_TEST       = 5'd18,
    FORM_CMP        = 5'd19,
    FORM_SETCC      = 5'd20,
    FORM_CVTSD2SI   = 5'd21,
    FORM_CVTSI2SD   = 5'd22,
    FORM_SQRTSD     = 5'd23,
    FORM_RET        = 5'd24,
    FORM_CQO        = 5'd25,
    FORM_SYSCALL    = 5'd26
  } form_t;

  // Opcode and prefix bytes.
  localparam logic [7:0] OP_REX      = 8'h40;
  localparam logic [7:0] OP_REX_B    = 8'h41;
  localparam logic [7:0] OP_REX_W    = 8'h48;
  localparam logic [7:0] OP_PUSH_R   = 8'h50;
  localparam logic [7:0] OP_POP_R    = 8'h58;
  localparam logic [7:0] OP_PUSH_I   = 8'h68;
  localparam logic [7:0] OP_GRP5     = 8'hFF;
  localparam logic [7:0] OP_POP_M    = 8'h8F;
  localparam logic [7:0] OP_GRP1     = 8'h81;
  localparam logic [7:0] OP_SUB      = 8'h29;
  localparam logic [7:0] OP_ADD      = 8'h01;
  localparam logic [7:0] OP_GRP3     = 8'hF7;
  localparam logic [7:0] OP_MOV      = 8'h89;
  localparam logic [7:0] OP_MOV_I    = 8'hB8;
  localparam logic [7:0] OP_JMP      = 8'hE9;
  localparam logic [7:0] OP_ESC      = 8'h0F;
  localparam logic [7:0] OP_JZ       = 8'h84;
  localparam logic [7:0] OP_CALL     = 8'hE8;
  localparam logic [7:0] OP_XOR      = 8'h31;
  localparam logic [7:0] OP_TEST     = 8'h85;
  localparam logic [7:0] OP_CMP      = 8'h39;
  localparam logic [7:0] OP_SD       = 8'hF2;
  localparam logic [7:0] OP_CVTSD2SI = 8'h2D;
  localparam logic [7:0] OP_CVTSI2SD = 8'h2A;
  localparam logic [7:0] OP_SQRTSD   = 8'h51;
  localparam logic [7:0] OP_RET      = 8'hC3;
  localparam logic [7:0] OP_CQO      = 8'h99;
  localparam logic [7:0] OP_SYSCALL  = 8'h05;
  localparam logic [7:0] SIB_RSP     = 8'h24;

  typedef struct packed {
    logic [4:0]         req_type;
    logic [3:0]         reg_a;
    logic [3:0]         reg_b;
    logic [2:0]         cond;
    logic signed [63:0] imm;
  } req_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last;
    logic [3:0] length;
  } rsp_t;

  // One encoded instruction: bytes in emission order, index 0 first.
  typedef struct packed {
    logic [MaxCode-1:0][7:0] bytes;
    logic [3:0]              len;
  } plan_t;

  function automatic logic [7:0] setcc_opcode(input logic [2:0] c);
    logic [7:0] op;
    case (c)
      3'd0:    op = 8'h9F;
      3'd1:    op = 8'h9C;
      3'd2:    op = 8'h9D;
      3'd3:    op = 8'h9E;
      3'd4:    op = 8'h94;
      3'd5:    op = 8'h95;
      3'd6:    op = 8'h94;
      default: op = 8'h95;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/x64_instruction_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x64_instruction_encoder_unit
// Encodes x86-64 instruction requests into a stream of machine code bytes.
// ----------------------------------------------------------------------------
// Usage: requests enter as queue pushes (in_push, in_full, in_data). Each
// request yields its machine code as one beat per byte on the result side
// (out_empty, out_pop, out_data), oldest first; every beat carries the total
// instruction length and the final beat of an instruction has last set.
// Forms outside the defined set produce no beats at all.
// A request is written into the queue, loaded from there into the byte walker,
// and its first byte then moves into the output register on the result ports.
// Throughput: one byte per cycle while the receiver keeps popping; a request
// yields 1 to 10 bytes. The front encodes a whole request combinationally
// and accepts one request per cycle while the queue of QDEPTH encoded
// instructions has room.
// Reset (synchronous, rst_n low) empties the queue and the output register.
// When the receiver holds off pop, the current beat stays on the ports, the
// walker pauses, and the queue fills until in_full rises.
// ----------------------------------------------------------------------------
module x64_instruction_encoder_unit
  import x64e_pkg::*;
#(
  parameter int QDEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  req_t in_data,
  output logic out_empty,
  input  logic out_pop,
  output rsp_t out_data
);

  plan_t f_plan;
  logic  f_ok;
  plan_t q_data;
  logic  q_empty;
  logic  q_pop;
  logic  q_full;

  x64e_front u_front (
    .req     (in_data),
    .plan    (f_plan),
    .plan_ok (f_ok)
  );

  x64e_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push && f_ok),
    .wr_data (f_plan),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  assign in_full = q_full;

  x64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> hw/rtl/x64e_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x64e_front
// Classifies a request and builds its complete byte sequence and length.
// ----------------------------------------------------------------------------
module x64e_front
  import x64e_pkg::*;
(
  input  req_t  req,
  output plan_t plan,
  output logic  plan_ok
);

  typedef struct packed {
    logic [5:0][7:0] b;
    logic [3:0]      n;
  } tail_t;

  function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] rg,
                                       input logic [2:0] rm);
    return {md, rg, rm};
  endfunction

  // ModRM with 32-bit displacement, plus a SIB byte when the base is rsp or r12.
  function automatic tail_t mem_tail(input logic [2:0] field, input logic [3:0] base,
                                     input logic [31:0] disp);
    tail_t t;
    t.b[0] = modrm(2'b10, field, base[2:0]);
    if (base[2:0] == 3'd4) begin
      t.b[1] = SIB_RSP;
      for (int j = 0; j < 4; j++) t.b[2+j] = disp[8*j +: 8];
      t.n = 4'd6;
    end else begin
      for (int j = 0; j < 4; j++) t.b[1+j] = disp[8*j +: 8];
      t.b[5] = 8'h00;
      t.n = 4'd5;
    end
    return t;
  endfunction

  logic [MaxCode-1:0][7:0] body;
  logic [3:0]              blen;
  logic                    pfx_en;
  logic [7:0]              pfx;
  tail_t                   tail;
  logic [3:0]              a;
  logic [3:0]              b;
  logic [7:0]              rex_rr;
  logic [7:0]              rex_r;

  assign a      = req.reg_a;
  assign b      = req.reg_b;
  assign rex_rr = {4'b0100, 1'b1, b[3], 1'b0, a[3]};
  assign rex_r  = {4'b0100, 1'b1, 1'b0, 1'b0, a[3]};

  always_comb begin
    body   = '0;
    blen   = 4'd0;
    pfx_en = 1'b0;
    pfx    = OP_REX_B;
    tail   = mem_tail((req.req_type == FORM_MOV_MEM) ? b[2:0] :
                      (req.req_type == FORM_PUSH_MEM) ? 3'd6 : 3'd0,
                      a, req.imm[31:0]);
    case (req.req_type)
      FORM_PUSH_REG, FORM_POP_REG: begin
        pfx_en  = a[3];
        body[0] = ((req.req_type == FORM_PUSH_REG) ? OP_PUSH_R : OP_POP_R)
                  + {5'd0, a[2:0]};
        blen    = 4'd1;
      end
      FORM_PUSH_MEM, FORM_POP_MEM: begin
        pfx_en  = a[3];
        body[0] = (req.req_type == FORM_PUSH_MEM) ? OP_GRP5 : OP_POP_M;
        for (int j = 0; j < 6; j++) body[1+j] = tail.b[j];
        blen    = tail.n + 4'd1;
      end
      FORM_MOV_MEM: begin
        pfx_en  = 1'b1;
        pfx     = rex_rr;
        body[0] = OP_MOV;
        for (int j = 0; j < 6; j++) body[1+j] = tail.b[j];
        blen    = tail.n + 4'd1;
      end
      FORM_PUSH_IMM, FORM_JMP, FORM_CALL: begin
        body[0] = (req.req_type == FORM_PUSH_IMM) ? OP_PUSH_I :
                  (req.req_type == FORM_JMP) ? OP_JMP : OP_CALL;
        for (int j = 0; j < 4; j++) body[1+j] = req.imm[8*j +: 8];
        blen    = 4'd5;
      end
      FORM_JZ: begin
        body[0] = OP_ESC;
        body[1] = OP_JZ;
        for (int j = 0; j < 4; j++) body[2+j] = req.imm[8*j +: 8];
        blen    = 4'd6;
      end
      FORM_SUB_IMM, FORM_ADD_IMM: begin
        pfx_en  = 1'b1;
        pfx     = rex_r;
        body[0] = OP_GRP1;
        body[1] = modrm(2'b11, (req.req_type == FORM_SUB_IMM) ? 3'd5 : 3'd0, a[2:0]);
        for (int j = 0; j < 4; j++) body[2+j] = req.imm[8*j +: 8];
        blen    = 4'd6;
      end
      FORM_IDIV, FORM_IMUL: begin
        pfx_en  = 1'b1;
        pfx     = rex_r;
        body[0] = OP_GRP3;
        body[1] = modrm(2'b11, (req.req_type == FORM_IDIV) ? 3'd7 : 3'd5, a[2:0]);
        blen    = 4'd2;
      end
      FORM_SUB_REG, FORM_ADD_REG, FORM_MOV_REG, FORM_XOR, FORM_TEST, FORM_CMP: begin
        pfx_en  = 1'b1;
        pfx     = rex_rr;
        case (req.req_type)
          FORM_SUB_REG: body[0] = OP_SUB;
          FORM_ADD_REG: body[0] = OP_ADD;
          FORM_MOV_REG: body[0] = OP_MOV;
          FORM_XOR:     body[0] = OP_XOR;
          FORM_TEST:    body[0] = OP_TEST;
          default:      body[0] = OP_CMP;
        endcase
        body[1] = modrm(2'b11, b[2:0], a[2:0]);
        blen    = 4'd2;
      end
      FORM_MOV_IMM64: begin
        pfx_en  = 1'b1;
        pfx     = rex_r;
        body[0] = OP_MOV_I + {5'd0, a[2:0]};
        for (int j = 0; j < 8; j++) body[1+j] = req.imm[8*j +: 8];
        blen    = 4'd9;
      end
      FORM_SETCC: begin
        // Byte registers 4 to 7 need a bare REX to mean spl, bpl, sil, dil.
        pfx_en  = a[2];
        pfx     = OP_REX;
        body[0] = OP_ESC;
        body[1] = setcc_opcode(req.cond);
        body[2] = modrm(2'b11, 3'd0, a[2:0]);
        blen    = 4'd3;
      end
      FORM_CVTSD2SI, FORM_CVTSI2SD: begin
        body[0] = OP_SD;
        body[1] = OP_REX_W;
        body[2] = OP_ESC;
        body[3] = (req.req_type == FORM_CVTSD2SI) ? OP_CVTSD2SI : OP_CVTSI2SD;
        body[4] = modrm(2'b11, a[2:0], b[2:0]);
        blen    = 4'd5;
      end
      FORM_SQRTSD: begin
        // The REX byte, when needed, sits between the F2 prefix and the escape.
        body[0] = OP_SD;
        if (a[3] || b[3]) begin
          body[1] = {4'b0100, 1'b0, a[3], 1'b0, b[3]};
          body[2] = OP_ESC;
          body[3] = OP_SQRTSD;
          body[4] = modrm(2'b11, a[2:0], b[2:0]);
          blen    = 4'd5;
        end else begin
          body[1] = OP_ESC;
          body[2] = OP_SQRTSD;
          body[3] = modrm(2'b11, a[2:0], b[2:0]);
          blen    = 4'd4;
        end
      end
      FORM_RET: begin
        body[0] = OP_RET;
        blen    = 4'd1;
      end
      FORM_CQO: begin
        body[0] = OP_REX_W;
        body[1] = OP_CQO;
        blen    = 4'd2;
      end
      FORM_SYSCALL: begin
        body[0] = OP_ESC;
        body[1] = OP_SYSCALL;
        blen    = 4'd2;
      end
      default: begin
        blen = 4'd0;
      end
    endcase
  end

  always_comb begin
    plan.bytes[0] = pfx_en ? pfx : body[0];
    for (int i = 1; i < MaxCode; i++) begin
      plan.bytes[i] = pfx_en ? body[i-1] : body[i];
    end
    plan.len = blen + {3'd0, pfx_en};
  end

  // Unknown forms encode to nothing; plan_ok low keeps them out of the queue.
  assign plan_ok = (blen != 4'd0);

endmodule
`default_nettype wire

>>> hw/rtl/x64e_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x64e_queue
// Short register queue of encoded instructions between front and back.
// ----------------------------------------------------------------------------
module x64e_queue
  import x64e_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  plan_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output plan_t rd_data,
  output logic  empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  plan_t            mem_r [DEPTH];
  logic [PtrW-1:0]  wptr_r, wptr_nxt;
  logic [PtrW-1:0]  rptr_r, rptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == LastPtr) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == LastPtr) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/x64e_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x64e_back
// Walks one encoded instruction and hands out one byte per beat.
// ----------------------------------------------------------------------------
module x64e_back
  import x64e_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_empty,
  input  plan_t q_data,
  output logic  q_pop,
  output logic  out_empty,
  input  logic  out_pop,
  output rsp_t  out_data
);

  plan_t           cur_r, cur_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic            busy_r, busy_nxt;
  logic            oval_r, oval_nxt;
  rsp_t            odat_r, odat_nxt;
  logic            adv;
  logic            cur_last;
  logic            load;

  // While an instruction is loaded, a byte moves into the output register
  // whenever that register is free or being drained in the same cycle.
  assign adv      = busy_r && (!oval_r || out_pop);
  assign cur_last = (4'(idx_r) == (cur_r.len - 4'd1));
  assign load     = (!busy_r || (adv && cur_last)) && !q_empty;
  assign q_pop    = load;

  always_comb begin
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    oval_nxt = oval_r;
    odat_nxt = odat_r;
    if (adv) begin
      odat_nxt.code_byte = cur_r.bytes[idx_r];
      odat_nxt.last      = cur_last;
      odat_nxt.length    = cur_r.len;
      oval_nxt           = 1'b1;
      idx_nxt            = idx_r + 1'b1;
      if (cur_last) begin
        busy_nxt = 1'b0;
      end
    end else if (out_pop) begin
      oval_nxt = 1'b0;
    end
    if (load) begin
      cur_nxt  = q_data;
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    odat_r <= odat_nxt;
  end

  assign out_empty = !oval_r;
  assign out_data  = odat_r;

endmodule
`default_nettype wire

>>> hw/rtl/x64e_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x64e_checker
// Port-level checks on the encoder's byte stream, bound to the top level.
// ----------------------------------------------------------------------------
module x64e_checker
  import x64e_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_empty,
  input wire logic out_pop,
  input wire rsp_t out_data
);

  // Within an instruction, popping a byte never leaves the result side empty.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_data.last) |=> !out_empty)
    else $error("gap inside an instruction's byte stream");

  // Every beat of one instruction carries the same length.
  a_len_same: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_data.last) |=>
      (out_data.length == $past(out_data.length)))
    else $error("length changed inside an instruction");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.length != 4'd0 && out_data.length <= 4'(MaxCode)))
    else $error("length outside one to ten");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled beat changed or vanished");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result side not empty after reset");

endmodule

bind x64_instruction_encoder_unit x64e_checker u_x64e_checker (.*);
`default_nettype wire

>>> test/tb_x64_instruction_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_x64_instruction_encoder_unit
// Checks the byte stream of the x86-64 encoder against a local encoder that
// rebuilds every instruction from its request. Directed requests cover every
// form and the prefix and SIB corner cases; random requests follow, with
// random gaps on both sides, long receiver stalls and drained pauses.
// ----------------------------------------------------------------------------
module tb_x64_instruction_encoder_unit
  import x64e_pkg::*;
();

  localparam int RESET_CYCLES   = 9;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_SPACING   = 700;
  localparam int RANDOM_BATCH   = 130;

  // ModRM fields and opcode extensions.
  localparam logic [1:0] MOD_DISP32 = 2'b10;
  localparam logic [1:0] MOD_REG    = 2'b11;
  localparam logic [2:0] RM_SIB     = 3'd4;
  localparam logic [2:0] EXT_PUSH   = 3'd6;
  localparam logic [2:0] EXT_POP    = 3'd0;
  localparam logic [2:0] EXT_SUB    = 3'd5;
  localparam logic [2:0] EXT_ADD    = 3'd0;
  localparam logic [2:0] EXT_IDIV   = 3'd7;
  localparam logic [2:0] EXT_IMUL   = 3'd5;
  localparam logic [2:0] EXT_SETCC  = 3'd0;

  localparam logic [2:0] COND_G      = 3'd0;
  localparam logic [2:0] COND_L      = 3'd1;
  localparam logic [2:0] COND_GE     = 3'd2;
  localparam logic [2:0] COND_LE     = 3'd3;
  localparam logic [2:0] COND_E      = 3'd4;
  localparam logic [2:0] COND_NE     = 3'd5;
  localparam logic [2:0] COND_ALT_E  = 3'd6;
  localparam logic [2:0] COND_ALT_NE = 3'd7;

  localparam logic [7:0] OP_SETG  = 8'h9F;
  localparam logic [7:0] OP_SETL  = 8'h9C;
  localparam logic [7:0] OP_SETGE = 8'h9D;
  localparam logic [7:0] OP_SETLE = 8'h9E;
  localparam logic [7:0] OP_SETE  = 8'h94;
  localparam logic [7:0] OP_SETNE = 8'h95;

  localparam logic [4:0] FORM_UNKNOWN_LO = 5'd27;
  localparam logic [4:0] FORM_UNKNOWN_HI = 5'd31;

  localparam logic [63:0] IMM_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] IMM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] IMM_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  req_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  rsp_t out_data;

  wire in_beat  = in_push && !in_full;
  wire out_beat = out_pop && !out_empty;

  req_t       pending_reqs[$];
  rsp_t       expected_beats[$];
  logic [7:0] code_buf[$];

  int  error_count = 0;
  int  beats_seen = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  send_calm = 0;
  int  pop_gap = 0;
  int  pop_calm = 0;
  int  next_hold_at = 200;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;

  x64_instruction_encoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- encoder

  function automatic logic [7:0] rex_byte(logic w, logic r, logic b);
    return OP_REX | {4'b0000, w, r, 1'b0, b};
  endfunction

  function automatic logic [7:0] modrm_byte(logic [1:0] md, logic [2:0] rg, logic [2:0] rm);
    return {md, rg, rm};
  endfunction

  function automatic void put_le(logic [63:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) code_buf.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_reg_reg(logic [7:0] op, logic [3:0] dst, logic [3:0] src);
    code_buf.push_back(rex_byte(1'b1, src[3], dst[3]));
    code_buf.push_back(op);
    code_buf.push_back(modrm_byte(MOD_REG, src[2:0], dst[2:0]));
  endfunction

  function automatic void put_reg_ext(logic [7:0] op, logic [2:0] ext, logic [3:0] rg);
    code_buf.push_back(rex_byte(1'b1, 1'b0, rg[3]));
    code_buf.push_back(op);
    code_buf.push_back(modrm_byte(MOD_REG, ext, rg[2:0]));
  endfunction

  // A base of rsp or r12 cannot be named in ModRM alone; it needs a SIB byte.
  function automatic void put_mem_tail(logic [2:0] field, logic [3:0] base, logic [63:0] disp);
    code_buf.push_back(modrm_byte(MOD_DISP32, field, base[2:0]));
    if (base[2:0] == RM_SIB) code_buf.push_back(SIB_RSP);
    put_le(disp, 4);
  endfunction

  function automatic void put_mem_ext(logic [7:0] op, logic [2:0] ext, logic [3:0] base,
                                      logic [63:0] disp);
    if (base[3]) code_buf.push_back(OP_REX_B);
    code_buf.push_back(op);
    put_mem_tail(ext, base, disp);
  endfunction

  function automatic logic [7:0] setcc_byte(logic [2:0] c);
    logic [7:0] op;
    case (c)
      COND_G:      op = OP_SETG;
      COND_L:      op = OP_SETL;
      COND_GE:     op = OP_SETGE;
      COND_LE:     op = OP_SETLE;
      COND_E:      op = OP_SETE;
      COND_NE:     op = OP_SETNE;
      COND_ALT_E:  op = OP_SETE;
      COND_ALT_NE: op = OP_SETNE;
      default:     op = OP_SETNE;
    endcase
    return op;
  endfunction

  // Encodes one request and queues one expected beat per code byte.
  function automatic void encode_request(req_t r);
    int n;
    rsp_t beat;
    code_buf.delete();
    case (r.req_type)
      FORM_PUSH_REG: begin
        if (r.reg_a[3]) code_buf.push_back(OP_REX_B);
        code_buf.push_back(OP_PUSH_R + 8'(r.reg_a[2:0]));
      end
      FORM_PUSH_IMM: begin
        code_buf.push_back(OP_PUSH_I);
        put_le(r.imm, 4);
      end
      FORM_PUSH_MEM: put_mem_ext(OP_GRP5, EXT_PUSH, r.reg_a, r.imm);
      FORM_POP_REG: begin
        if (r.reg_a[3]) code_buf.push_back(OP_REX_B);
        code_buf.push_back(OP_POP_R + 8'(r.reg_a[2:0]));
      end
      FORM_POP_MEM: put_mem_ext(OP_POP_M, EXT_POP, r.reg_a, r.imm);
      FORM_SUB_IMM: begin
        put_reg_ext(OP_GRP1, EXT_SUB, r.reg_a);
        put_le(r.imm, 4);
      end
      FORM_SUB_REG: put_reg_reg(OP_SUB, r.reg_a, r.reg_b);
      FORM_ADD_IMM: begin
        put_reg_ext(OP_GRP1, EXT_ADD, r.reg_a);
        put_le(r.imm, 4);
      end
      FORM_ADD_REG: put_reg_reg(OP_ADD, r.reg_a, r.reg_b);
      FORM_IDIV:    put_reg_ext(OP_GRP3, EXT_IDIV, r.reg_a);
      FORM_IMUL:    put_reg_ext(OP_GRP3, EXT_IMUL, r.reg_a);
      FORM_MOV_REG: put_reg_reg(OP_MOV, r.reg_a, r.reg_b);
      FORM_MOV_MEM: begin
        code_buf.push_back(rex_byte(1'b1, r.reg_b[3], r.reg_a[3]));
        code_buf.push_back(OP_MOV);
        put_mem_tail(r.reg_b[2:0], r.reg_a, r.imm);
      end
      FORM_MOV_IMM64: begin
        code_buf.push_back(rex_byte(1'b1, 1'b0, r.reg_a[3]));
        code_buf.push_back(OP_MOV_I + 8'(r.reg_a[2:0]));
        put_le(r.imm, 8);
      end
      FORM_JMP: begin
        code_buf.push_back(OP_JMP);
        put_le(r.imm, 4);
      end
      FORM_JZ: begin
        code_buf.push_back(OP_ESC);
        code_buf.push_back(OP_JZ);
        put_le(r.imm, 4);
      end
      FORM_CALL: begin
        code_buf.push_back(OP_CALL);
        put_le(r.imm, 4);
      end
      FORM_XOR:  put_reg_reg(OP_XOR, r.reg_a, r.reg_b);
      FORM_TEST: put_reg_reg(OP_TEST, r.reg_a, r.reg_b);
      FORM_CMP:  put_reg_reg(OP_CMP, r.reg_a, r.reg_b);
      FORM_SETCC: begin
        // Byte registers 4 to 7 mean spl..dil only with a REX byte present.
        if (r.reg_a[2]) code_buf.push_back(OP_REX);
        code_buf.push_back(OP_ESC);
        code_buf.push_back(setcc_byte(r.cond));
        code_buf.push_back(modrm_byte(MOD_REG, EXT_SETCC, r.reg_a[2:0]));
      end
      FORM_CVTSD2SI, FORM_CVTSI2SD: begin
        code_buf.push_back(OP_SD);
        code_buf.push_back(OP_REX_W);
        code_buf.push_back(OP_ESC);
        code_buf.push_back(r.req_type == FORM_CVTSD2SI ? OP_CVTSD2SI : OP_CVTSI2SD);
        code_buf.push_back(modrm_byte(MOD_REG, r.reg_a[2:0], r.reg_b[2:0]));
      end
      FORM_SQRTSD: begin
        code_buf.push_back(OP_SD);
        if (r.reg_a[3] || r.reg_b[3])
          code_buf.push_back(rex_byte(1'b0, r.reg_a[3], r.reg_b[3]));
        code_buf.push_back(OP_ESC);
        code_buf.push_back(OP_SQRTSD);
        code_buf.push_back(modrm_byte(MOD_REG, r.reg_a[2:0], r.reg_b[2:0]));
      end
      FORM_RET: code_buf.push_back(OP_RET);
      FORM_CQO: begin
        code_buf.push_back(OP_REX_W);
        code_buf.push_back(OP_CQO);
      end
      FORM_SYSCALL: begin
        code_buf.push_back(OP_ESC);
        code_buf.push_back(OP_SYSCALL);
      end
      default: ;
    endcase
    n = code_buf.size();
    for (int k = 0; k < n; k++) begin
      beat.code_byte = code_buf[k];
      beat.last      = (k == n - 1);
      beat.length    = 4'(n);
      expected_beats.push_back(beat);
    end
  endfunction

  // --------------------------------------------------------------- stimulus

  // Mostly back-to-back, sometimes short or long gaps, now and then a calm run.
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 62) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic void queue_req(logic [4:0] t, logic [3:0] a, logic [3:0] b,
                                    logic [2:0] c, logic [63:0] imm);
    req_t r;
    r.req_type = t;
    r.reg_a    = a;
    r.reg_b    = b;
    r.cond     = c;
    r.imm      = imm;
    pending_reqs.push_back(r);
  endfunction

  function automatic req_t random_req();
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.req_type = (pick < 6) ? 5'($urandom_range(FORM_UNKNOWN_LO, FORM_UNKNOWN_HI))
                            : 5'($urandom_range(FORM_PUSH_REG, FORM_SYSCALL));
    r.reg_a = 4'($urandom);
    r.reg_b = 4'($urandom);
    r.cond  = 3'($urandom);
    case ($urandom_range(0, 5))
      0:       r.imm = IMM_MIN;
      1:       r.imm = IMM_MAX;
      2:       r.imm = 64'(signed'(32'($urandom)));
      default: r.imm = {$urandom, $urandom};
    endcase
    return r;
  endfunction

  // ----------------------------------------------------------------- driver

  always @(posedge clk) begin
    in_taken = rst_n && in_beat;
    if (in_taken) begin
      encode_request(in_data);
      void'(pending_reqs.pop_front());
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || in_taken) begin
      if (send_gap > 0) begin
        in_push <= 1'b0;
        send_gap--;
      end else if (pending_reqs.size() != 0) begin
        in_push <= 1'b1;
        in_data <= pending_reqs[0];
        send_gap = pick_gap(send_calm);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    rsp_t want;
    out_taken = rst_n && out_beat;
    if (out_taken) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: code_byte %h last %b length %0d",
               out_data.code_byte, out_data.last, out_data.length);
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        if (out_data.code_byte !== want.code_byte) begin
          $error("code_byte: expected %h, actual %h", want.code_byte, out_data.code_byte);
          error_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_data.last);
          error_count++;
        end
        if (out_data.length !== want.length) begin
          $error("length: expected %0d, actual %0d", want.length, out_data.length);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_taken) pop_gap = pick_gap(pop_calm);
      // A long stall lets the block fill up and push back on the sender.
      if (beats_seen >= next_hold_at) begin
        pop_gap = LONG_HOLD;
        next_hold_at += HOLD_SPACING;
      end
      if (pop_gap > 0) begin
        out_pop <= 1'b0;
        pop_gap--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (in_beat || out_beat) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------- flow

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_beats.size() != 0) @(negedge clk);
  endtask

  task automatic add_random(int count);
    int counted;
    req_t r;
    counted = 0;
    // Unknown forms are ignored by the block and do not count.
    while (counted < count) begin
      r = random_req();
      pending_reqs.push_back(r);
      if (r.req_type <= FORM_SYSCALL) counted++;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_req(FORM_PUSH_REG, 4'd15, 4'd0, COND_G, 64'd0);
    queue_req(FORM_PUSH_IMM, 4'd0, 4'd0, COND_G, IMM_MIN);
    queue_req(FORM_PUSH_MEM, 4'd12, 4'd0, COND_G, 64'h0000_0000_1234_5678);
    queue_req(FORM_POP_REG, 4'd0, 4'd15, COND_G, 64'd0);
    queue_req(FORM_POP_MEM, 4'd4, 4'd0, COND_G, IMM_ONES);
    queue_req(FORM_SUB_IMM, 4'd15, 4'd0, COND_G, IMM_ONES);
    queue_req(FORM_SUB_REG, 4'd15, 4'd0, COND_G, 64'd0);
    queue_req(FORM_ADD_IMM, 4'd0, 4'd0, COND_G, IMM_MAX);
    queue_req(FORM_ADD_REG, 4'd0, 4'd15, COND_G, 64'd0);
    queue_req(FORM_IDIV, 4'd8, 4'd0, COND_G, 64'd0);
    queue_req(FORM_IMUL, 4'd7, 4'd0, COND_G, 64'd0);
    queue_req(FORM_MOV_REG, 4'd15, 4'd15, COND_G, 64'd0);
    queue_req(FORM_MOV_MEM, 4'd12, 4'd15, COND_G, 64'h0000_0000_8000_0000);
    queue_req(FORM_MOV_IMM64, 4'd15, 4'd0, COND_G, IMM_MIN);
    queue_req(FORM_MOV_IMM64, 4'd0, 4'd0, COND_G, IMM_MAX);
    queue_req(FORM_JMP, 4'd0, 4'd0, COND_G, 64'd0);
    queue_req(FORM_JZ, 4'd0, 4'd0, COND_G, 64'h0000_0000_7FFF_FFFF);
    queue_req(FORM_CALL, 4'd0, 4'd0, COND_G, IMM_ONES);
    queue_req(FORM_XOR, 4'd8, 4'd7, COND_G, 64'd0);
    queue_req(FORM_TEST, 4'd7, 4'd8, COND_G, 64'd0);
    queue_req(FORM_CMP, 4'd4, 4'd12, COND_G, 64'd0);
    queue_req(FORM_SETCC, 4'd4, 4'd0, COND_ALT_E, 64'd0);
    queue_req(FORM_SETCC, 4'd15, 4'd0, COND_ALT_NE, 64'd0);
    queue_req(FORM_SETCC, 4'd3, 4'd0, COND_G, 64'd0);
    queue_req(FORM_CVTSD2SI, 4'd15, 4'd9, COND_G, 64'd0);
    queue_req(FORM_CVTSI2SD, 4'd8, 4'd0, COND_G, 64'd0);
    queue_req(FORM_SQRTSD, 4'd8, 4'd3, COND_G, 64'd0);
    queue_req(FORM_SQRTSD, 4'd2, 4'd7, COND_G, 64'd0);
    queue_req(FORM_RET, 4'd0, 4'd0, COND_G, 64'd0);
    queue_req(FORM_CQO, 4'd0, 4'd0, COND_G, 64'd0);
    queue_req(FORM_SYSCALL, 4'd0, 4'd0, COND_G, 64'd0);
    queue_req(FORM_UNKNOWN_LO, 4'd15, 4'd15, COND_ALT_NE, IMM_ONES);
    queue_req(FORM_UNKNOWN_HI, 4'd0, 4'd0, COND_G, 64'd0);
    wait_drained();

    add_random(RANDOM_BATCH);
    wait_drained();

    add_random(RANDOM_BATCH);
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
